/* hdl/ppp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole point projector package
// shared types, codes and saturation helper for the projection pipeline
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int SCREEN_WIDTH_DEF  = 960;
   localparam int SCREEN_HEIGHT_DEF = 544;

   localparam int POSE_WORDS = 12;
   localparam int DIV_NW     = 64;
   localparam int DIV_DW     = 32;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   localparam logic [1:0] ST_ON_SCREEN  = 2'd0;
   localparam logic [1:0] ST_TOO_NEAR   = 2'd1;
   localparam logic [1:0] ST_OFF_SCREEN = 2'd2;

   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_SCALE     = 3'd4;
   localparam logic [2:0] REG_OFFSET_X  = 3'd5;
   localparam logic [2:0] REG_OFFSET_Y  = 3'd6;
   localparam logic [2:0] REG_MIN_DEPTH = 3'd7;

   localparam logic [30:0] SCALE_RESET = 31'd98304;

   typedef struct packed {
      logic        valid;
      logic        rej;
      logic [63:0] num_x;
      logic [63:0] num_y;
      logic [31:0] den;
   } cam_out_type;

   typedef struct packed {
      logic        valid;
      logic        rej;
      logic [63:0] q_x;
      logic [63:0] q_y;
   } div_out_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/ppp_cam.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// camera transform
// pose products, saturated camera coordinates, depth test and focal products
// ----------------------------------------------------------------------------
module ppp_cam #(
   parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  wire                  in_valid,
   input  wire  [31:0]          point_x,
   input  wire  [31:0]          point_y,
   input  wire  [31:0]          point_z,
   input  wire  [11:0][31:0]    pose,
   input  wire  [30:0]          focal_x,
   input  wire  [30:0]          focal_y,
   input  wire  [31:0]          min_depth,
   output ppp_pkg::cam_out_type cam_out
);

   logic signed [63:0] prod_ff [3][3];
   logic signed [63:0] prod_in [3][3];
   logic        [31:0] tr_ff   [3];
   logic               v1_ff;
   logic        [31:0] cc_ff   [3];
   logic        [31:0] cc_in   [3];
   logic               v2_ff;
   ppp_pkg::cam_out_type c3_ff, c3_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(pose[r*4+0]) * $signed(point_x);
         prod_in[r][1] = $signed(pose[r*4+1]) * $signed(point_y);
         prod_in[r][2] = $signed(pose[r*4+2]) * $signed(point_z);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cc_in[r] = ppp_pkg::sat32((prod_ff[r][0] >>> FRAC_BITS)
                                 + (prod_ff[r][1] >>> FRAC_BITS)
                                 + (prod_ff[r][2] >>> FRAC_BITS)
                                 + 64'($signed(tr_ff[r])));
      end
   end

   always_comb begin
      c3_in.valid = v2_ff;
      c3_in.rej   = ($signed(cc_ff[2]) <= $signed(min_depth)) || (cc_ff[2] == 32'd0);
      c3_in.num_x = $signed({1'b0, focal_x}) * $signed(cc_ff[0]);
      c3_in.num_y = $signed({1'b0, focal_y}) * $signed(cc_ff[1]);
      c3_in.den   = cc_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         c3_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff       <= in_valid;
         v2_ff       <= v1_ff;
         c3_ff.valid <= c3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         for (int r = 0; r < 3; r++) begin
            tr_ff[r] <= pose[r*4+3];
         end
         cc_ff      <= cc_in;
         c3_ff.rej   <= c3_in.rej;
         c3_ff.num_x <= c3_in.num_x;
         c3_ff.num_y <= c3_in.num_y;
         c3_ff.den   <= c3_in.den;
      end
   end

   assign cam_out = c3_ff;

endmodule
`default_nettype wire

/* hdl/ppp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pipelined divider
// signed truncating division of two numerators by a shared depth, one
// quotient bit per stage
// ----------------------------------------------------------------------------
module ppp_div (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  ppp_pkg::cam_out_type div_in,
   output ppp_pkg::div_out_type div_out
);

   localparam int NW = ppp_pkg::DIV_NW;
   localparam int DW = ppp_pkg::DIV_DW;

   logic [NW-1:0] nqx_ff [NW+1];
   logic [NW-1:0] nqy_ff [NW+1];
   logic [DW-1:0] rx_ff  [NW+1];
   logic [DW-1:0] ry_ff  [NW+1];
   logic [DW-1:0] d_ff   [NW+1];
   logic          nx_ff  [NW+1];
   logic          ny_ff  [NW+1];
   logic          rej_ff [NW+1];
   logic          v_ff   [NW+1];
   ppp_pkg::div_out_type o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= div_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nqx_ff[0] <= div_in.num_x[63] ? -div_in.num_x : div_in.num_x;
         nqy_ff[0] <= div_in.num_y[63] ? -div_in.num_y : div_in.num_y;
         d_ff[0]   <= div_in.den[31] ? -div_in.den : div_in.den;
         rx_ff[0]  <= '0;
         ry_ff[0]  <= '0;
         nx_ff[0]  <= div_in.num_x[63] ^ div_in.den[31];
         ny_ff[0]  <= div_in.num_y[63] ^ div_in.den[31];
         rej_ff[0] <= div_in.rej;
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_step
      logic [DW:0]   tx, ty, sx, sy;
      logic [DW-1:0] rx_in, ry_in;
      logic [NW-1:0] nqx_in, nqy_in;

      always_comb begin
         tx     = {rx_ff[k-1], nqx_ff[k-1][NW-1]};
         ty     = {ry_ff[k-1], nqy_ff[k-1][NW-1]};
         sx     = tx - {1'b0, d_ff[k-1]};
         sy     = ty - {1'b0, d_ff[k-1]};
         rx_in  = sx[DW] ? tx[DW-1:0] : sx[DW-1:0];
         ry_in  = sy[DW] ? ty[DW-1:0] : sy[DW-1:0];
         nqx_in = {nqx_ff[k-1][NW-2:0], ~sx[DW]};
         nqy_in = {nqy_ff[k-1][NW-2:0], ~sy[DW]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k]  <= rx_in;
            ry_ff[k]  <= ry_in;
            nqx_ff[k] <= nqx_in;
            nqy_ff[k] <= nqy_in;
            d_ff[k]   <= d_ff[k-1];
            nx_ff[k]  <= nx_ff[k-1];
            ny_ff[k]  <= ny_ff[k-1];
            rej_ff[k] <= rej_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ff.valid <= 1'b0;
      end else if (en) begin
         o_ff.valid <= v_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff.rej <= rej_ff[NW];
         o_ff.q_x <= nx_ff[NW] ? -nqx_ff[NW] : nqx_ff[NW];
         o_ff.q_y <= ny_ff[NW] ? -nqy_ff[NW] : nqy_ff[NW];
      end
   end

   assign div_out = o_ff;

endmodule
`default_nettype wire

/* hdl/ppp_scr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// screen mapping
// principal point, display scale, offset, bounds test and response register
// ----------------------------------------------------------------------------
module ppp_scr #(
   parameter int FRAC_BITS     = ppp_pkg::FRAC_BITS_DEF,
   parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  en,
   input  ppp_pkg::div_out_type scr_in,
   input  wire  [30:0]          center_x,
   input  wire  [30:0]          center_y,
   input  wire  [30:0]          display_scale,
   input  wire  [31:0]          offset_x,
   input  wire  [31:0]          offset_y,
   output logic                 out_valid,
   output logic [9:0]           pixel_x,
   output logic [9:0]           pixel_y,
   output logic [1:0]           status
);

   localparam logic signed [63:0] WLIM = 64'(SCREEN_WIDTH) << FRAC_BITS;
   localparam logic signed [63:0] HLIM = 64'(SCREEN_HEIGHT) << FRAC_BITS;

   logic               va_ff, vb_ff, ra_ff, rb_ff;
   logic        [31:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [63:0] mx_ff, my_ff;
   logic signed [63:0] u_c, v_c;
   logic               on_c;
   logic               val_ff;
   logic [9:0]         px_ff, py_ff;
   logic [1:0]         st_ff, st_in;

   always_comb begin
      cx_in = ppp_pkg::sat32(64'($signed(ppp_pkg::sat32($signed(scr_in.q_x))))
                             + 64'(center_x));
      cy_in = ppp_pkg::sat32(64'($signed(ppp_pkg::sat32($signed(scr_in.q_y))))
                             + 64'(center_y));
   end

   always_comb begin
      u_c  = (mx_ff >>> FRAC_BITS) + 64'($signed(offset_x));
      v_c  = (my_ff >>> FRAC_BITS) + 64'($signed(offset_y));
      on_c = (u_c >= 0) && (u_c < WLIM) && (v_c >= 0) && (v_c < HLIM);
      if (rb_ff) begin
         st_in = ppp_pkg::ST_TOO_NEAR;
      end else if (!on_c) begin
         st_in = ppp_pkg::ST_OFF_SCREEN;
      end else begin
         st_in = ppp_pkg::ST_ON_SCREEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         val_ff <= 1'b0;
      end else if (en) begin
         va_ff  <= scr_in.valid;
         vb_ff  <= va_ff;
         val_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff <= scr_in.rej;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         rb_ff <= ra_ff;
         mx_ff <= $signed(cx_ff) * $signed({1'b0, display_scale});
         my_ff <= $signed(cy_ff) * $signed({1'b0, display_scale});
         st_ff <= st_in;
         if (st_in == ppp_pkg::ST_ON_SCREEN) begin
            px_ff <= u_c[FRAC_BITS+9:FRAC_BITS];
            py_ff <= v_c[FRAC_BITS+9:FRAC_BITS];
         end else begin
            px_ff <= '0;
            py_ff <= '0;
         end
      end
   end

   assign out_valid = val_ff;
   assign pixel_x   = px_ff;
   assign pixel_y   = py_ff;
   assign status    = st_ff;

endmodule
`default_nettype wire

/* hdl/pinhole_point_projector_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole point projector
// projects world points through a loaded 3x4 pose onto the display
//
// req channel: tuser is the opcode, load a pose word or project a point.
// a load with a pose index below 12 updates the pose store at acceptance
// and gives no response; a project request gives exactly one response,
// in request order. rsp channel: pixel column and row, status in tuser.
// each project request passes through the camera stages, the 64-stage
// quotient pipeline and the screen stages on its way to rsp_tvalid.
// throughput is one request per cycle while no response waits with rsp_tready low.
// reset clears the pipeline valid bits and the csr registers, but the
// display scale resets to 98304; pose words must be loaded before use.
// when rsp_tready is low with a response waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
// csr writes are taken at any cycle with csr_we high.
// ----------------------------------------------------------------------------
module pinhole_point_projector_unit #(
   parameter int FRAC_BITS     = ppp_pkg::FRAC_BITS_DEF,
   parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // pose_index, pose_value, point_x, point_y, point_z, zero fill
   input  wire  [135:0] req_tdata,
   // opcode
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // pixel_x, pixel_y, zero fill
   output logic [23:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_wdata
);

   logic              en, acc;
   logic [11:0][31:0] pose_ff;
   logic [30:0]       focal_x_ff, focal_y_ff, center_x_ff, center_y_ff, scale_ff;
   logic [31:0]       offset_x_ff, offset_y_ff, min_depth_ff;
   logic [3:0]        pose_index;
   logic [9:0]        pixel_x, pixel_y;
   ppp_pkg::cam_out_type cam_out;
   ppp_pkg::div_out_type div_out;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;
   assign pose_index = req_tdata[3:0];

   always_ff @(posedge clock) begin
      if (acc && (req_tuser[0] == ppp_pkg::OP_LOAD) && (pose_index < 4'(ppp_pkg::POSE_WORDS)))
      begin
         pose_ff[pose_index] <= req_tdata[35:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= '0;
         focal_y_ff   <= '0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         scale_ff     <= ppp_pkg::SCALE_RESET;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         min_depth_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ppp_pkg::REG_FOCAL_X:   focal_x_ff   <= csr_wdata[30:0];
            ppp_pkg::REG_FOCAL_Y:   focal_y_ff   <= csr_wdata[30:0];
            ppp_pkg::REG_CENTER_X:  center_x_ff  <= csr_wdata[30:0];
            ppp_pkg::REG_CENTER_Y:  center_y_ff  <= csr_wdata[30:0];
            ppp_pkg::REG_SCALE:     scale_ff     <= csr_wdata[30:0];
            ppp_pkg::REG_OFFSET_X:  offset_x_ff  <= csr_wdata;
            ppp_pkg::REG_OFFSET_Y:  offset_y_ff  <= csr_wdata;
            ppp_pkg::REG_MIN_DEPTH: min_depth_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppp_cam #(.FRAC_BITS(FRAC_BITS)) u_cam (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (acc && (req_tuser[0] == ppp_pkg::OP_PROJECT)),
      .point_x   (req_tdata[67:36]),
      .point_y   (req_tdata[99:68]),
      .point_z   (req_tdata[131:100]),
      .pose      (pose_ff),
      .focal_x   (focal_x_ff),
      .focal_y   (focal_y_ff),
      .min_depth (min_depth_ff),
      .cam_out   (cam_out)
   );

   ppp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (cam_out),
      .div_out (div_out)
   );

   ppp_scr #(
      .FRAC_BITS     (FRAC_BITS),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_scr (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .scr_in        (div_out),
      .center_x      (center_x_ff),
      .center_y      (center_y_ff),
      .display_scale (scale_ff),
      .offset_x      (offset_x_ff),
      .offset_y      (offset_y_ff),
      .out_valid     (rsp_tvalid),
      .pixel_x       (pixel_x),
      .pixel_y       (pixel_y),
      .status        (rsp_tuser)
   );

   assign rsp_tdata = {4'd0, pixel_y, pixel_x};

endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// pinhole point projector testbench
// drives load and project requests with random idling and stalls through
// several csr settings, predicts each pixel and status in fixed point and
// compares every response in order
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [9:0] px;
      logic [9:0] py;
      logic [1:0] st;
   } pixel_type;

   class projection_scoreboard;
      longint pose[12];
      longint fx, fy, cx, cy, scale, ox, oy, mind;
      pixel_type pending[$];
      int     failures;

      function new();
         foreach (pose[i]) pose[i] = 0;
         fx = 0; fy = 0; cx = 0; cy = 0; scale = longint'(ppp_pkg::SCALE_RESET);
         ox = 0; oy = 0; mind = 0;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] d);
         longint u, s;
         u = longint'(d[30:0]);
         s = longint'($signed(d));
         case (idx)
            ppp_pkg::REG_FOCAL_X:   fx = u;
            ppp_pkg::REG_FOCAL_Y:   fy = u;
            ppp_pkg::REG_CENTER_X:  cx = u;
            ppp_pkg::REG_CENTER_Y:  cy = u;
            ppp_pkg::REG_SCALE:     scale = u;
            ppp_pkg::REG_OFFSET_X:  ox = s;
            ppp_pkg::REG_OFFSET_Y:  oy = s;
            ppp_pkg::REG_MIN_DEPTH: mind = s;
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint cam_coord(int row, longint x, longint y, longint z);
         return clamp32((pose[row*4] * x >>> 16) + (pose[row*4+1] * y >>> 16) +
                        (pose[row*4+2] * z >>> 16) + pose[row*4+3]);
      endfunction

      function longint screen_coord(longint f, longint c, longint d, longint ctr,
                                    longint off);
         longint q;
         q = clamp32((f * c) / d);
         q = clamp32(q + ctr);
         return ((q * scale) >>> 16) + off;
      endfunction

      function void note_request(logic op, logic [3:0] idx, logic [31:0] val,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z);
         longint xc, yc, zc, u, v;
         pixel_type e;
         if (op == ppp_pkg::OP_LOAD) begin
            if (idx < 12) pose[idx] = longint'($signed(val));
            return;
         end
         xc = cam_coord(0, $signed(x), $signed(y), $signed(z));
         yc = cam_coord(1, $signed(x), $signed(y), $signed(z));
         zc = cam_coord(2, $signed(x), $signed(y), $signed(z));
         e.px = 0; e.py = 0;
         if (zc <= mind || zc == 0) begin
            e.st = ppp_pkg::ST_TOO_NEAR;
         end else begin
            u = screen_coord(fx, xc, zc, cx, ox);
            v = screen_coord(fy, yc, zc, cy, oy);
            if (u < 0 || u >= (64'sd960 <<< 16) || v < 0 || v >= (64'sd544 <<< 16)) begin
               e.st = ppp_pkg::ST_OFF_SCREEN;
            end else begin
               e.st = ppp_pkg::ST_ON_SCREEN;
               e.px = u[25:16];
               e.py = v[25:16];
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(logic [9:0] px, logic [9:0] py, logic [1:0] st);
         pixel_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response px=%0d py=%0d st=%0d", $time, px, py, st);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (px !== e.px || py !== e.py || st !== e.st) begin
            $display("%0t mismatch expected px=%0d py=%0d st=%0d actual px=%0d py=%0d st=%0d",
                     $time, e.px, e.py, e.st, px, py, st);
            failures++;
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [135:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   projection_scoreboard sb;
   int gap_pct, stall_pct, quiet;

   pinhole_point_projector_unit uut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[9:0], rsp_tdata[19:10], rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet = 0;
         else quiet++;
         if (quiet >= 3000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic push(logic op, logic [3:0] idx, logic [31:0] val,
                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, z, y, x, val, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, idx, val, x, y, z);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_regs(logic [31:0] v[8]);
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         @(negedge clock);
         sb.write_reg(3'(i), v[i]);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] near_fix(int lo, int hi);
      return 32'($signed(32'($urandom_range(0, hi - lo))) + lo);
   endfunction

   task automatic load_pose();
      logic [31:0] w;
      for (int i = 0; i < 12; i++) begin
         if (i % 4 == 3) w = (i == 11) ? near_fix(0, 5 << 16) : near_fix(-65536, 65536);
         else if (i % 5 == 0) w = near_fix(60000, 71000);
         else w = near_fix(-8000, 8000);
         push(ppp_pkg::OP_LOAD, 4'(i), w, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic nice_config(output logic [31:0] v[8], input bit wide_offsets);
      logic [31:0] f;
      f = $urandom_range(100, 600) << 16;
      v[0] = f; v[1] = f + ($urandom_range(0, 40) << 16);
      v[2] = 32'd480 << 16; v[3] = 32'd272 << 16;
      v[4] = $urandom_range(32768, 131072);
      v[5] = wide_offsets ? near_fix(-(300 << 16), 300 << 16) : near_fix(-(20 << 16), 20 << 16);
      v[6] = wide_offsets ? near_fix(-(300 << 16), 300 << 16) : near_fix(-(20 << 16), 20 << 16);
      v[7] = near_fix(-(1 << 16), 1 << 16);
   endtask

   initial begin
      logic [31:0] r[8];
      int k;
      sb = new();
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = ppp_pkg::OP_LOAD;
      rsp_tready = 1'b0; csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      gap_pct = 10; stall_pct = 61; quiet = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: identity pose, ignored loads, corner points
      r = '{32'd300 << 16, 32'd300 << 16, 32'd480 << 16, 32'd272 << 16,
            32'd65536, 32'd0, 32'd0, 32'hFFFF_0000};
      write_regs(r);
      for (int i = 0; i < 12; i++)
         push(ppp_pkg::OP_LOAD, 4'(i), (i % 5 == 0) ? 32'd65536 : 32'd0, 0, 0, 0);
      push(ppp_pkg::OP_LOAD, 4'd12, $urandom, 0, 0, 0);
      push(ppp_pkg::OP_LOAD, 4'd15, $urandom, 0, 0, 0);
      push(ppp_pkg::OP_PROJECT, 0, 0, 0, 0, 32'd5 << 16);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'd1 << 16, 32'hFFFF_0000, 32'd2 << 16);
      push(ppp_pkg::OP_PROJECT, 0, 0, 0, 0, 0);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'd1 << 14, 0, 32'hFFFF_8000);
      push(ppp_pkg::OP_PROJECT, 0, 0, 0, 0, 32'hFFFC_0000);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'd100 << 16, 0, 32'd1 << 16);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'hFF9C_0000, 0, 32'd1 << 16);
      push(ppp_pkg::OP_PROJECT, 4'hF, 32'hFFFF_FFFF,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
      push(ppp_pkg::OP_PROJECT, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);

      for (int blk = 0; blk < 6; blk++) begin
         gap_pct   = (blk < 2) ? 10 : (blk < 4) ? 61 : 0;
         stall_pct = (blk < 2) ? 61 : (blk < 4) ? 10 : 0;
         case (blk)
            1: r = '{default: 32'h7FFF_FFFF};
            2: r = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            3: foreach (r[i]) r[i] = $urandom;
            4: nice_config(r, 1'b1);
            default: nice_config(r, 1'b0);
         endcase
         write_regs(r);
         for (k = 0; k < 175; k++) begin
            if (k % 70 == 0) load_pose();
            case ($urandom_range(99)) inside
               [0:7]:  push(ppp_pkg::OP_LOAD, 4'($urandom), $urandom,
                            $urandom, $urandom, $urandom);
               [8:11]: push(ppp_pkg::OP_LOAD, 4'($urandom_range(0, 11)),
                            near_fix(-70000, 70000), $urandom, $urandom, $urandom);
               [12:27]: push(ppp_pkg::OP_PROJECT, 4'($urandom), $urandom,
                             $urandom, $urandom, $urandom);
               default: push(ppp_pkg::OP_PROJECT, 4'($urandom), $urandom,
                             near_fix(-(3 << 16), 3 << 16), near_fix(-(3 << 16), 3 << 16),
                             near_fix(1 << 15, 20 << 16));
            endcase
            if (k == 100 && blk == 0) drain();
         end
      end

      drain();
      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* pinhole_point_projector_unit.f */
hdl/ppp_pkg.sv
hdl/ppp_cam.sv
hdl/ppp_div.sv
hdl/ppp_scr.sv
hdl/pinhole_point_projector_unit.sv
sim/tb.sv
